// ----- rtl/core/block_transposition_cipher_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef BLOCK_TRANSPOSITION_CIPHER_CORE_DEFINES_SVH
`define BLOCK_TRANSPOSITION_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/btc_pkg.sv -----
package btc_pkg;

    // Fixed field and register widths
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int KEY_ENT_W   = 4;
    localparam int KEY_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Filler for decrypt positions that receive no byte
    localparam logic [BYTE_W-1:0] FILL_CHAR = 8'h5F;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_TABLE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } btc_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } btc_out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic enc_step;
        logic scat_step;
        logic emit_step;
    } btc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic flush;
        logic mode;
        logic enc_qual;
        logic j_end;
        logic q_end;
        logic slot_free;
    } btc_status_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ENC  = 4'b0010,
        ST_SCAT = 4'b0100,
        ST_EMIT = 4'b1000
    } btc_state_t;

endpackage

// ----- rtl/core/block_transposition_cipher_core.sv -----
// Channel   Handshake             Word
// in        in_valid / in_ready   in_data  : in_byte, in_last
// out       out_valid / out_ready out_data : out_byte, out_last
// cfg       cfg_wr_en             cfg_index, cfg_data (0 mode, 1 block_len, 2 key_table)
//
// Each byte is taken in the idle state; a byte that completes a block then holds
// the input for a key scan over L entries (encrypt) or an L-entry scatter scan plus
// an emit of the n buffered bytes (decrypt), L the block length and n the buffered bytes.
// One input byte buffer sets this: the next block waits until the scan and any emit end.
// Reset clears control and configuration at once; the buffer needs no clearing.
// A busy output stalls the scan on the word that waits for the slot.
module block_transposition_cipher_core #(
    parameter int MAX_BLOCK = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  btc_pkg::btc_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output btc_pkg::btc_out_t              out_data
);
    import btc_pkg::*;

    btc_cmd_t    cmd;
    btc_status_t status;

    btc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    btc_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/core/btc_datapath.sv -----
module btc_datapath #(
    parameter int MAX_BLOCK = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [btc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [btc_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  btc_pkg::btc_in_t                        in_data,
    input  btc_pkg::btc_cmd_t                       cmd,
    output btc_pkg::btc_status_t                    status,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output btc_pkg::btc_out_t                       out_data
);
    import btc_pkg::*;

    localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CW = $clog2(MAX_BLOCK + 1);

    // Configuration registers
    logic                mode_reg;
    logic [LEN_W-1:0]    block_len_reg;
    logic [KEY_W-1:0]    key_reg;

    // Block control
    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       n_reg;
    logic                last_reg;
    logic [IW-1:0]       j_reg;
    logic [CW-1:0]       p_reg;
    logic [IW-1:0]       q_reg;
    logic [MAX_BLOCK-1:0] filled_reg;

    // Byte buffers
    logic [BYTE_W-1:0]   store_mem [MAX_BLOCK];
    logic [BYTE_W-1:0]   plain_mem [MAX_BLOCK];

    logic                out_valid_reg;
    btc_out_t            out_data_reg;

    logic [LEN_W-1:0]    eff_len;
    logic [LEN_W-1:0]    fill_plus;
    logic [KEY_ENT_W-1:0] key_j;
    logic                key_qual;
    logic                scat_qual;
    logic                more_after;
    logic [IW-1:0]       rd_addr;
    logic                slot_free;
    logic                load_enc;
    logic                load_emit;

    // Clamp block length to 1..MAX_BLOCK
    always_comb
    begin
        if (block_len_reg == '0)
            eff_len = LEN_W'(1);
        else if (block_len_reg > LEN_W'(MAX_BLOCK))
            eff_len = LEN_W'(MAX_BLOCK);
        else
            eff_len = block_len_reg;
    end

    assign fill_plus = LEN_W'(fill_reg) + LEN_W'(1);
    assign key_j     = key_reg[{j_reg, 2'b00} +: KEY_ENT_W];
    assign key_qual  = LEN_W'(key_j) < LEN_W'(n_reg);
    assign scat_qual = key_qual && (LEN_W'(p_reg) < LEN_W'(n_reg));

    // Look for a usable key entry beyond the current one
    always_comb
    begin
        more_after = 1'b0;
        for (int i = 0; i < MAX_BLOCK; i++)
        begin
            if ((LEN_W'(i) > LEN_W'(j_reg)) && (LEN_W'(i) < eff_len) &&
                (LEN_W'(key_reg[i*KEY_ENT_W +: KEY_ENT_W]) < LEN_W'(n_reg)))
                more_after = 1'b1;
        end
    end

    // Gather reads by key, scatter reads in arrival order
    assign rd_addr   = mode_reg ? p_reg[IW-1:0] : key_j[IW-1:0];

    assign slot_free = !out_valid_reg || out_ready;
    assign load_enc  = cmd.enc_step && key_qual;
    assign load_emit = cmd.emit_step;

    always_comb
    begin
        status.flush     = (fill_plus >= eff_len) || in_data.in_last;
        status.mode      = mode_reg;
        status.enc_qual  = key_qual;
        status.j_end     = (LEN_W'(j_reg) + LEN_W'(1)) == eff_len;
        status.q_end     = (LEN_W'(q_reg) + LEN_W'(1)) == LEN_W'(n_reg);
        status.slot_free = slot_free;
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            block_len_reg <= LEN_W'(1);
            key_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[0];
                REG_BLOCK_LEN: block_len_reg <= cfg_data[LEN_W-1:0];
                REG_KEY_TABLE: key_reg       <= cfg_data[KEY_W-1:0];
                default:       ;
            endcase
        end
    end

    // Advance fill, scan and emit counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            n_reg      <= '0;
            last_reg   <= 1'b0;
            j_reg      <= '0;
            p_reg      <= '0;
            q_reg      <= '0;
            filled_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (status.flush)
                begin
                    fill_reg   <= '0;
                    n_reg      <= fill_reg + CW'(1);
                    last_reg   <= in_data.in_last;
                    j_reg      <= '0;
                    p_reg      <= '0;
                    q_reg      <= '0;
                    filled_reg <= '0;
                end
                else
                    fill_reg <= fill_reg + CW'(1);
            end
            if (cmd.enc_step)
                j_reg <= j_reg + IW'(1);
            if (cmd.scat_step)
            begin
                j_reg <= j_reg + IW'(1);
                if (scat_qual)
                begin
                    filled_reg[key_j[IW-1:0]] <= 1'b1;
                    p_reg <= p_reg + CW'(1);
                end
            end
            if (cmd.emit_step)
                q_reg <= q_reg + IW'(1);
        end
    end

    // Write byte buffers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            store_mem[fill_reg[IW-1:0]] <= in_data.in_byte;
        if (cmd.scat_step && scat_qual)
            plain_mem[key_j[IW-1:0]] <= store_mem[rd_addr];
    end

    // Hold the output word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_enc || load_emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_enc)
        begin
            out_data_reg.out_byte <= store_mem[rd_addr];
            out_data_reg.out_last <= last_reg && !more_after;
        end
        else if (load_emit)
        begin
            out_data_reg.out_byte <= filled_reg[q_reg] ? plain_mem[q_reg] : FILL_CHAR;
            out_data_reg.out_last <= last_reg && status.q_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/core/btc_ctrl.sv -----
module btc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  btc_pkg::btc_status_t  status,
    output btc_pkg::btc_cmd_t     cmd
);
    import btc_pkg::*;

    btc_state_t state_reg;
    btc_state_t state_next;

    // Sequence accept, gather, scatter and emit phases
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.enc_step  = 1'b0;
        cmd.scat_step = 1'b0;
        cmd.emit_step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.flush)
                    state_next = status.mode ? ST_SCAT : ST_ENC;
            end
            ST_ENC:
            begin
                // stall only when a usable entry finds the output slot busy
                if (!status.enc_qual || status.slot_free)
                begin
                    cmd.enc_step = 1'b1;
                    if (status.j_end)
                        state_next = ST_IDLE;
                end
            end
            ST_SCAT:
            begin
                cmd.scat_step = 1'b1;
                if (status.j_end)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.q_end)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/core/btc_checker.sv -----
`include "block_transposition_cipher_core_defines.svh"

module btc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input btc_pkg::btc_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input btc_pkg::btc_out_t out_data
);
    import btc_pkg::*;

    // A stalled output word holds
    `BTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")

    // New output words appear only while the input side is busy
    `BTC_ASSERT_NOW(a_out_from_busy, $rose(out_valid), !$past(in_ready), "output word loaded while idle")

    // A final input byte always starts a block flush
    `BTC_ASSERT_NEXT(a_last_flush, in_valid && in_ready && in_data.in_last, !in_ready, "final byte did not flush the block")

endmodule

bind block_transposition_cipher_core btc_checker u_btc_checker (.*);
